// ===== hw/rtl/exposure_warning_overlay_top_defines.svh =====
// assertion macros for the exposure warning overlay
`ifndef EXPOSURE_WARNING_OVERLAY_TOP_DEFINES_SVH
`define EXPOSURE_WARNING_OVERLAY_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define EWO_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("overlay assertion failed");

`define EWO_ASSERT(lbl, prop) `EWO_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define EWO_ASSERT_CLK(lbl, clk, rst_n, prop)

`define EWO_ASSERT(lbl, prop)

`endif

`endif

// ===== hw/rtl/ewo_pkg.sv =====
package ewo_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned LumaW  = 8;

  typedef enum logic [ModeW-1:0] {
    ModeNone      = 3'd0,
    ModeShadow    = 3'd1,
    ModeHighlight = 3'd2,
    ModeGamut     = 3'd3,
    ModeFalse     = 3'd4
  } mode_e;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t colour;
    logic  marked;
  } overlay_t;

  // luma weights in q0.16, summing to one
  localparam logic [15:0] LumaCoefR = 16'd13933;
  localparam logic [15:0] LumaCoefG = 16'd46871;
  localparam logic [15:0] LumaCoefB = 16'd4732;

  localparam logic [ChanW-1:0] ShadowLimit    = 8'd1;
  localparam logic [ChanW-1:0] HighlightLimit = 8'd254;
  localparam logic [ChanW-1:0] GamutHigh      = 8'd250;
  localparam logic [ChanW-1:0] GamutLow       = 8'd5;
  // pairwise difference sum equals twice the max-min span, so 430 becomes 215
  localparam logic [ChanW-1:0] GamutSpan      = 8'd215;

  localparam logic [LumaW-1:0] ZoneLimit [6] = '{
    8'd16, 8'd48, 8'd88, 8'd132, 8'd176, 8'd220
  };

  localparam rgba_t ZoneRgba [7] = '{
    '{8'd33,  8'd47,  8'd155, 8'd175},
    '{8'd30,  8'd124, 8'd214, 8'd165},
    '{8'd28,  8'd170, 8'd132, 8'd160},
    '{8'd96,  8'd194, 8'd87,  8'd150},
    '{8'd238, 8'd205, 8'd78,  8'd155},
    '{8'd239, 8'd122, 8'd46,  8'd165},
    '{8'd232, 8'd48,  8'd60,  8'd180}
  };

  localparam rgba_t ShadowRgba    = '{8'd54,  8'd178, 8'd255, 8'd165};
  localparam rgba_t HighlightRgba = '{8'd255, 8'd86,  8'd64,  8'd165};
  localparam rgba_t GamutRgba     = '{8'd244, 8'd82,  8'd255, 8'd165};
  localparam rgba_t ClearRgba     = '{8'd0,   8'd0,   8'd0,   8'd0};

  // residue mod 3 by summing base-4 digits
  function automatic logic [1:0] mod3_12(logic [11:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s  = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

endpackage

// ===== hw/rtl/ewo_luma.sv =====
module ewo_luma (
  input  logic [ewo_pkg::ChanW-1:0] red_i,
  input  logic [ewo_pkg::ChanW-1:0] green_i,
  input  logic [ewo_pkg::ChanW-1:0] blue_i,
  output logic [ewo_pkg::LumaW-1:0] luma_o
);
  import ewo_pkg::*;

  logic [23:0] prod_r;
  logic [23:0] prod_g;
  logic [23:0] prod_b;
  logic [23:0] sum;

  assign prod_r = 24'(LumaCoefR) * 24'(red_i);
  assign prod_g = 24'(LumaCoefG) * 24'(green_i);
  assign prod_b = 24'(LumaCoefB) * 24'(blue_i);
  // weights sum to 65536, so the integer part never exceeds 255
  assign sum    = prod_r + prod_g + prod_b;
  assign luma_o = sum[23:16];

endmodule

// ===== hw/rtl/ewo_classify.sv =====
module ewo_classify (
  input  logic [ewo_pkg::ModeW-1:0] mode_i,
  input  ewo_pkg::pixel_t           pixel_i,
  input  logic [ewo_pkg::LumaW-1:0] luma_i,
  output ewo_pkg::overlay_t         overlay_o
);
  import ewo_pkg::*;

  logic [ChanW-1:0]  r;
  logic [ChanW-1:0]  g;
  logic [ChanW-1:0]  b;
  logic [ChanW-1:0]  hi;
  logic [ChanW-1:0]  lo;
  logic [CoordW:0]   pos_sum;
  logic              dither_pass;
  logic              test_pass;
  rgba_t             mode_colour;
  rgba_t             zone_colour;

  assign r = pixel_i.red;
  assign g = pixel_i.green;
  assign b = pixel_i.blue;

  always_comb begin
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
  end

  // (x mod 6) < 4 exactly when (x >> 1) mod 3 is not 2
  assign pos_sum     = {1'b0, pixel_i.column} + {1'b0, pixel_i.row};
  assign dither_pass = (mod3_12(pos_sum[CoordW:1]) != 2'd2);

  always_comb begin
    if (luma_i < ZoneLimit[0])      zone_colour = ZoneRgba[0];
    else if (luma_i < ZoneLimit[1]) zone_colour = ZoneRgba[1];
    else if (luma_i < ZoneLimit[2]) zone_colour = ZoneRgba[2];
    else if (luma_i < ZoneLimit[3]) zone_colour = ZoneRgba[3];
    else if (luma_i < ZoneLimit[4]) zone_colour = ZoneRgba[4];
    else if (luma_i < ZoneLimit[5]) zone_colour = ZoneRgba[5];
    else                            zone_colour = ZoneRgba[6];
  end

  always_comb begin
    case (mode_i)
      ModeShadow: begin
        test_pass   = (r <= ShadowLimit) || (g <= ShadowLimit) ||
                      (b <= ShadowLimit) || (luma_i <= ShadowLimit);
        mode_colour = ShadowRgba;
      end
      ModeHighlight: begin
        test_pass   = (r >= HighlightLimit) || (g >= HighlightLimit) ||
                      (b >= HighlightLimit) || (luma_i >= HighlightLimit);
        mode_colour = HighlightRgba;
      end
      ModeGamut: begin
        test_pass   = ((hi >= GamutHigh) && (lo <= GamutLow)) ||
                      ((hi - lo) > GamutSpan);
        mode_colour = GamutRgba;
      end
      ModeFalse: begin
        test_pass   = 1'b1;
        mode_colour = zone_colour;
      end
      default: begin
        test_pass   = 1'b0;
        mode_colour = ClearRgba;
      end
    endcase
  end

  always_comb begin
    overlay_o.marked = test_pass && dither_pass;
    overlay_o.colour = overlay_o.marked ? mode_colour : ClearRgba;
  end

endmodule

// ===== hw/rtl/exposure_warning_overlay_top.sv =====
// exposure warning overlay
// input channel: present red/green/blue with column/row and raise start;
// a transaction is taken at a rising edge with start high and busy low.
// busy is held low, so one pixel may be given in every cycle.
// result channel: valid_o is high for exactly one cycle with the overlay
// colour and marked flag; the receiver cannot stall it, and nothing holds
// results back. an accepted pixel goes through one input register, then luma,
// test and colour logic into the result register.
// throughput is one pixel per cycle, set by the single-pass datapath.
// configuration: cfg_we_i with cfg_data_i writes the overlay mode
// (0 none, 1 shadow clip, 2 highlight clip, 3 gamut, 4 false colour,
// other codes act as none); write it only while no pixel is in flight.
// reset: rst_ni low clears the mode to none and drops all in-flight
// pixels; no result is strobed until a new pixel is taken.
`include "exposure_warning_overlay_top_defines.svh"

module exposure_warning_overlay_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [ewo_pkg::ModeW-1:0] cfg_data_i,
  input  logic [ewo_pkg::ChanW-1:0] red_i,
  input  logic [ewo_pkg::ChanW-1:0] green_i,
  input  logic [ewo_pkg::ChanW-1:0] blue_i,
  input  logic [ewo_pkg::CoordW-1:0] column_i,
  input  logic [ewo_pkg::CoordW-1:0] row_i,
  output logic                      valid_o,
  output logic [ewo_pkg::ChanW-1:0] out_red_o,
  output logic [ewo_pkg::ChanW-1:0] out_green_o,
  output logic [ewo_pkg::ChanW-1:0] out_blue_o,
  output logic [ewo_pkg::ChanW-1:0] out_alpha_o,
  output logic                      marked_o
);
  import ewo_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             in_valid_q;
  pixel_t           pixel_q;
  logic             out_valid_q;
  overlay_t         result_q;
  logic [LumaW-1:0] luma;
  overlay_t         result_d;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeNone;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= '{red: red_i, green: green_i, blue: blue_i,
                   column: column_i, row: row_i};
    end
    if (in_valid_q) result_q <= result_d;
  end

  ewo_luma u_luma (
    .red_i   (pixel_q.red),
    .green_i (pixel_q.green),
    .blue_i  (pixel_q.blue),
    .luma_o  (luma)
  );

  ewo_classify u_classify (
    .mode_i    (mode_q),
    .pixel_i   (pixel_q),
    .luma_i    (luma),
    .overlay_o (result_d)
  );

  assign valid_o     = out_valid_q;
  assign out_red_o   = result_q.colour.red;
  assign out_green_o = result_q.colour.green;
  assign out_blue_o  = result_q.colour.blue;
  assign out_alpha_o = result_q.colour.alpha;
  assign marked_o    = result_q.marked;

  `EWO_ASSERT(a_latency_two, accept |-> ##2 valid_o)
  `EWO_ASSERT(a_unmarked_clear, (valid_o && !marked_o) |-> (result_q.colour == ClearRgba))
  `EWO_ASSERT(a_none_never_marks, (valid_o && $past(mode_q) == ModeNone) |-> !marked_o)
  `EWO_ASSERT(a_marked_opaque, (valid_o && marked_o) |-> (out_alpha_o != '0))

endmodule
